### design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table sizes, request and status codes, and the control bundle that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEPTH  = 64;
	localparam int KEY_W  = 32;
	localparam int IDX_W  = $clog2(DEPTH + 1);
	localparam int CELL_W = $clog2(DEPTH);
	localparam int REQ_W  = 3;
	localparam int STAT_W = 2;

	// stream word layouts, padded to whole bytes
	localparam int S_DATA_W  = ((REQ_W + KEY_W + 7) / 8) * 8;
	localparam int KEY_LSB   = 1;
	localparam int IDX_LSB   = KEY_LSB + KEY_W;
	localparam int CNT_LSB   = IDX_LSB + IDX_W;
	localparam int STAT_LSB  = CNT_LSB + IDX_W;
	localparam int M_FIELD_W = STAT_LSB + STAT_W;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_SEEK   = 3'd1,
		REQ_FIRST  = 3'd2,
		REQ_LAST   = 3'd3,
		REQ_NEXT   = 3'd4,
		REQ_PREV   = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_RO   = 2'd2
	} status_t;

	typedef struct packed {
		logic             wr_en;
		logic [KEY_W-1:0] key;
	} cell_ctl_t;

endpackage

### design/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key, and on insert either
// keeps its key, takes the left neighbor's key, or takes the new key.
// ----------------------------------------------------------------------------
module skt_cell (
	input  logic                       clk,
	input  skt_pkg::cell_ctl_t         ctl,
	input  logic                       occ,       // slot holds a stored key
	input  logic [skt_pkg::KEY_W-1:0]  left_key,
	input  logic                       left_ge,
	output logic [skt_pkg::KEY_W-1:0]  stored_key,
	output logic                       ge
);

	logic [skt_pkg::KEY_W-1:0] key_q;

	// empty slots count as "not less", so the first one marks the append spot
	assign ge         = occ ? (key_q >= ctl.key) : 1'b1;
	assign stored_key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ge) begin
			key_q <= left_ge ? left_key : ctl.key;
		end
	end

endmodule

### design/sorted_insert_key_table.sv
// ----------------------------------------------------------------------------
// sorted_insert_key_table: ascending key table with cursor
// Chain of compare-and-shift cells keeps keys sorted; a small sequencer
// handles insert, seek and cursor moves and reports the cursor entry.
// ----------------------------------------------------------------------------
// After a request is accepted, the cell chain compare/shift is registered,
// then the cursor cell select is loaded into the result register.
// A new request is accepted only once the previous result has been loaded
// into the result register, so a stalled result register holds off input.
// Reset: entry count, cursor and read_only clear; cell keys are not reset
// and only slots below the entry count are ever read.
module sorted_insert_key_table (
	input  logic                          clk,
	input  logic                          arst_n,
	// request: [2:0] req_type, [34:3] key, [39:35] zero
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skt_pkg::S_DATA_W-1:0]  s_tdata,
	// result: [0] cursor_valid, [32:1] cursor_key, [39:33] cursor_index,
	// [46:40] entry_count, [48:47] status, [55:49] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skt_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int DEPTH  = skt_pkg::DEPTH;
	localparam int KEY_W  = skt_pkg::KEY_W;
	localparam int IDX_W  = skt_pkg::IDX_W;
	localparam int CELL_W = skt_pkg::CELL_W;
	localparam int REQ_W  = skt_pkg::REQ_W;
	localparam int M_W    = skt_pkg::M_DATA_W;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ} state_t;

	state_t                      state_q;
	logic [skt_pkg::REQ_W-1:0]   req_q;
	logic [KEY_W-1:0]            key_q;
	logic [IDX_W-1:0]            count_q;
	logic [IDX_W-1:0]            cursor_q;
	logic [skt_pkg::STAT_W-1:0]  status_q;
	logic                        ro_q;
	logic                        out_valid_q;
	logic [M_W-1:0]              out_data_q;

	skt_pkg::cell_ctl_t          ctl;
	logic [DEPTH-1:0]            occ;
	logic [DEPTH-1:0]            ge;
	logic [DEPTH-1:0]            first_ge;
	logic [KEY_W-1:0]            cell_key [DEPTH];
	logic [CELL_W-1:0]           lb_enc;
	logic [IDX_W-1:0]            lb;
	logic                        ins_ok;
	logic [IDX_W-1:0]            cursor_d;
	logic [skt_pkg::STAT_W-1:0]  status_d;
	logic [IDX_W-1:0]            count_d;
	logic [KEY_W-1:0]            sel_key;
	logic                        cur_valid;
	logic                        cfg_wr;
	logic                        out_load;

	function automatic logic [CELL_W-1:0] onehot_index(input logic [DEPTH-1:0] v);
		logic [CELL_W-1:0] r;
		r = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (v[i]) r = r | CELL_W'(i);
		end
		return r;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, ro_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q <= 1'b0;
		end else if (cfg_wr) begin
			ro_q <= pwdata[0];
		end
	end

	// cell chain
	assign ins_ok    = (req_q == skt_pkg::REQ_INSERT) && !ro_q && (count_q != IDX_W'(DEPTH));
	assign ctl.wr_en = (state_q == ST_EXEC) && ins_ok;
	assign ctl.key   = key_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = IDX_W'(i) < count_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_W-1:0] lk;
		logic             lg;
		if (g == 0) begin : g_head
			assign lk = '0;
			assign lg = 1'b0;
		end else begin : g_link
			assign lk = cell_key[g-1];
			assign lg = ge[g-1];
		end
		skt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ[g]),
			.left_key   (lk),
			.left_ge    (lg),
			.stored_key (cell_key[g]),
			.ge         (ge[g])
		);
		assign first_ge[g] = ge[g] && !lg;
	end

	// lower bound: first slot not less than the key, else end of a full table
	assign lb_enc = onehot_index(first_ge);
	assign lb     = (|first_ge) ? IDX_W'(lb_enc) : count_q;

	always_comb begin
		cursor_d = cursor_q;
		status_d = skt_pkg::STAT_OK;
		count_d  = count_q;
		unique case (req_q)
			skt_pkg::REQ_INSERT: begin
				if (ro_q) begin
					status_d = skt_pkg::STAT_RO;
				end else if (count_q == IDX_W'(DEPTH)) begin
					status_d = skt_pkg::STAT_FULL;
				end else begin
					count_d = count_q + IDX_W'(1);
				end
				cursor_d = count_d;
			end
			skt_pkg::REQ_SEEK:  cursor_d = lb;
			skt_pkg::REQ_FIRST: cursor_d = '0;
			skt_pkg::REQ_LAST:  cursor_d = (count_q != '0) ? count_q - IDX_W'(1) : '0;
			skt_pkg::REQ_NEXT: begin
				if (cursor_q < count_q) cursor_d = cursor_q + IDX_W'(1);
			end
			skt_pkg::REQ_PREV:  cursor_d = (cursor_q == '0) ? count_q : cursor_q - IDX_W'(1);
			default: ;
		endcase
	end

	// cursor cell select
	assign cur_valid = cursor_q < count_q;
	always_comb begin
		sel_key = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cursor_q == IDX_W'(i)) sel_key = sel_key | cell_key[i];
		end
		if (!cur_valid) sel_key = '0;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_load = (state_q == ST_READ) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= skt_pkg::REQ_INSERT;
			key_q       <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			status_q    <= skt_pkg::STAT_OK;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q   <= s_tdata[REQ_W-1:0];
						key_q   <= s_tdata[REQ_W +: KEY_W];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					count_q  <= count_d;
					cursor_q <= cursor_d;
					status_q <= status_d;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// result register: load from the read stage, else drop once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= M_W'({status_q, count_q, cursor_q, sel_key, cur_valid});
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Watches requests and results on the top level ports.
// ----------------------------------------------------------------------------
module skt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [skt_pkg::M_DATA_W-1:0]  m_tdata
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tdata[skt_pkg::IDX_LSB +: skt_pkg::IDX_W] <=
				m_tdata[skt_pkg::CNT_LSB +: skt_pkg::IDX_W]) &&
			(m_tdata[skt_pkg::CNT_LSB +: skt_pkg::IDX_W] <=
				skt_pkg::IDX_W'(skt_pkg::DEPTH)))
		else $error("cursor or count out of range");

	// valid flag means cursor below count; at end the key reads zero
	a_cursor_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tdata[0] == (m_tdata[skt_pkg::IDX_LSB +: skt_pkg::IDX_W] <
				m_tdata[skt_pkg::CNT_LSB +: skt_pkg::IDX_W])) &&
			(m_tdata[0] || (m_tdata[skt_pkg::KEY_LSB +: skt_pkg::KEY_W] == '0)))
		else $error("cursor valid flag inconsistent");

endmodule

bind sorted_insert_key_table skt_checker u_skt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/sorted_insert_key_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_key_table_tb: self-checking bench for the sorted key table
// Streams insert, seek and cursor-move requests with random idle and stall
// patterns. A scoreboard keeps its own sorted table and cursor, predicts the
// cursor report for every accepted request and checks the results in order.
// The read_only register is toggled over the APB port between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_insert_key_table_tb;

	localparam logic [2:0] REQ_UNUSED_A  = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B  = 3'd7;
	localparam logic [2:0] ADDR_READ_ONLY = 3'd0;
	localparam int         N_PHASES      = 8;
	localparam int         PHASE_REQS    = 120;
	localparam int         DRAIN_CYCLES  = 8;

	class key_table_scoreboard;
		logic [skt_pkg::KEY_W-1:0] keys [skt_pkg::DEPTH];
		int unsigned       n_keys;
		int unsigned       cursor;
		bit                read_only;
		logic [48:0]       report_q [$];
		int unsigned       mismatches;

		function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
			if (mismatches < 10)
				$display("%0t: %s expected %0h got %0h", $realtime, what, exp_v, act_v);
			mismatches++;
		endfunction

		function int unsigned find_slot(logic [skt_pkg::KEY_W-1:0] probe);
			int unsigned i;
			for (i = 0; i < n_keys; i++)
				if (keys[i] >= probe) return i;
			return n_keys;
		endfunction

		function void note_request(logic [2:0] req, logic [skt_pkg::KEY_W-1:0] key);
			int unsigned     pos;
			logic [1:0]      status;
			logic [skt_pkg::KEY_W-1:0] cur_key;
			logic [48:0]     entry;
			status = skt_pkg::STAT_OK;
			case (req)
				skt_pkg::REQ_INSERT: begin
					if (read_only) begin
						status = skt_pkg::STAT_RO;
					end else if (n_keys >= skt_pkg::DEPTH) begin
						status = skt_pkg::STAT_FULL;
					end else begin
						pos = find_slot(key);
						for (int i = n_keys; i > pos; i--)
							keys[i] = keys[i-1];
						keys[pos] = key;
						n_keys++;
					end
					cursor = n_keys;
				end
				skt_pkg::REQ_SEEK:  cursor = find_slot(key);
				skt_pkg::REQ_FIRST: cursor = 0;
				skt_pkg::REQ_LAST:  cursor = (n_keys != 0) ? n_keys - 1 : 0;
				skt_pkg::REQ_NEXT:  if (cursor < n_keys) cursor++;
				skt_pkg::REQ_PREV:  cursor = (cursor == 0) ? n_keys : cursor - 1;
				default: ;
			endcase
			cur_key = (cursor < n_keys) ? keys[cursor] : '0;
			entry = {status, 7'(n_keys), 7'(cursor), cur_key, 1'(cursor < n_keys)};
			report_q = {report_q, entry};
		endfunction

		function void check_result(logic [55:0] word);
			logic [48:0] want;
			if (report_q.size() == 0) begin
				flag("result with no request pending", '0, 64'(word));
				return;
			end
			want = report_q.pop_front();
			if (word[0] !== want[0])
				flag("cursor_valid", 64'(want[0]), 64'(word[0]));
			if (word[32:1] !== want[32:1])
				flag("cursor_key", 64'(want[32:1]), 64'(word[32:1]));
			if (word[39:33] !== want[39:33])
				flag("cursor_index", 64'(want[39:33]), 64'(word[39:33]));
			if (word[46:40] !== want[46:40])
				flag("entry_count", 64'(want[46:40]), 64'(word[46:40]));
			if (word[48:47] !== want[48:47])
				flag("status", 64'(want[48:47]), 64'(word[48:47]));
			if (word[55:49] !== '0)
				flag("result padding", '0, 64'(word[55:49]));
		endfunction

		function int unsigned pending();
			return report_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// request: [2:0] req_type, [34:3] key, [39:35] zero
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// result: [0] cursor_valid, [32:1] cursor_key, [39:33] cursor_index,
	// [46:40] entry_count, [48:47] status, [55:49] zero
	logic [55:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	key_table_scoreboard board = new();
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	logic [skt_pkg::KEY_W-1:0] key_pool [8];

	sorted_insert_key_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check on handshake, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic send_request(input logic [2:0] req,
			input logic [skt_pkg::KEY_W-1:0] key);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, key, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(req, key);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_read_only(input bit ro);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_READ_ONLY;
		pwdata  <= {31'd0, ro};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'd0, ro})
			board.flag("read_only readback", 64'({31'd0, ro}), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		board.read_only = ro;
		@(posedge clk);
	endtask

	function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return key_pool[$urandom_range(7)];
			default: return $urandom;
		endcase
	endfunction

	// when keys are stored, half the probes land on or next to a stored key
	function automatic logic [skt_pkg::KEY_W-1:0] pick_probe();
		logic [skt_pkg::KEY_W-1:0] hit;
		if (board.n_keys == 0 || $urandom_range(1) == 0)
			return pick_key();
		hit = board.keys[$urandom_range(board.n_keys - 1)];
		case ($urandom_range(2))
			0:       return hit - 1'b1;
			1:       return hit;
			default: return hit + 1'b1;
		endcase
	endfunction

	task automatic random_request();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 22)      send_request(skt_pkg::REQ_INSERT, pick_key());
		else if (roll < 42) send_request(skt_pkg::REQ_SEEK, pick_probe());
		else if (roll < 50) send_request(skt_pkg::REQ_FIRST, $urandom);
		else if (roll < 58) send_request(skt_pkg::REQ_LAST, $urandom);
		else if (roll < 76) send_request(skt_pkg::REQ_NEXT, $urandom);
		else if (roll < 94) send_request(skt_pkg::REQ_PREV, $urandom);
		else if (roll < 97) send_request(REQ_UNUSED_A, $urandom);
		else                send_request(REQ_UNUSED_B, $urandom);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_read_only(1'b0);

		// empty table corners
		send_request(skt_pkg::REQ_LAST, 32'h0);
		send_request(skt_pkg::REQ_PREV, 32'h0);
		send_request(skt_pkg::REQ_NEXT, 32'h0);
		send_request(skt_pkg::REQ_FIRST, 32'h0);
		send_request(skt_pkg::REQ_SEEK, 32'h0);
		// extremes and a duplicate
		send_request(skt_pkg::REQ_INSERT, 32'h8000_0000);
		send_request(skt_pkg::REQ_INSERT, 32'h0000_0000);
		send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		send_request(skt_pkg::REQ_INSERT, 32'h8000_0000);
		send_request(skt_pkg::REQ_INSERT, 32'h5555_5555);
		send_request(skt_pkg::REQ_INSERT, 32'hAAAA_AAAA);
		send_request(skt_pkg::REQ_SEEK, 32'h8000_0000);
		send_request(skt_pkg::REQ_SEEK, 32'hFFFF_FFFF);
		send_request(skt_pkg::REQ_SEEK, 32'h8000_0001);
		// prev at first wraps to end, prev from end goes to last
		send_request(skt_pkg::REQ_FIRST, 32'hFFFF_FFFF);
		send_request(skt_pkg::REQ_PREV, 32'h0);
		send_request(skt_pkg::REQ_PREV, 32'h0);
		send_request(skt_pkg::REQ_NEXT, 32'h0);
		send_request(skt_pkg::REQ_NEXT, 32'h0);
		send_request(REQ_UNUSED_A, 32'h1234_5678);
		send_request(REQ_UNUSED_B, 32'hEDCB_A987);
		drain();
		set_read_only(1'b1);
		send_request(skt_pkg::REQ_INSERT, 32'h0000_1234);
		send_request(skt_pkg::REQ_SEEK, 32'h0);
		drain();
		set_read_only(1'b0);

		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
				default: begin src_idle_pct = 23; snk_stall_pct = 23; end
			endcase
			repeat (PHASE_REQS) random_request();
			drain();
			set_read_only(phase == 1 || phase == 4);
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;
		drain();

		if (board.mismatches == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_insert_key_table.sv
design/skt_checker.sv
verif/sorted_insert_key_table_tb.sv
